>>> hdl/sti_pkg.sv
// Shared types and defaults for the sorted key table.
// Used by sti_cell, sti_locate and sorted_table_insert_search; no dependencies.
`timescale 1ns / 1ps

package sti_pkg;

  localparam int DEPTH_DEFAULT     = 64;
  localparam int KEY_WIDTH_DEFAULT = 32;

  typedef enum logic [1:0] {
    CMD_LOOKUP  = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_FIND_GE = 2'd2,
    CMD_DELETE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RES
  } state_t;

  // Shared control driven from the sequencer into every cell.
  typedef struct packed {
    logic load_flags;
    logic do_ins;
    logic do_del;
  } cell_ctrl_t;

endpackage

>>> hdl/sorted_table_insert_search.sv
// Sorted key table: lookup, insert if absent, find greater or equal, delete.
// Top level; depends on sti_pkg, sti_cell and sti_locate.
`timescale 1ns / 1ps

// A row of DEPTH cells holds the keys in stored order. For an accepted
// beat, every cell first compares its entry with the key in S_CMP; then in
// S_RES the lowest not-below slot is found and the cells shift for insert
// or delete while the result is registered. A new beat is taken in the
// cycle a result is registered, so the table does not take a new command
// before it is through with the last one; a result that is not taken holds
// the row. The entries need no clearing after reset, and the user must
// write key_signed through cfg_we and cfg_wdata only while the table is
// idle; the block itself does not enforce this.
module sorted_table_insert_search #(
  parameter int DEPTH     = sti_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = sti_pkg::KEY_WIDTH_DEFAULT,
  parameter int IW        = $clog2(DEPTH),
  parameter int CW        = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [IW-1:0]        in_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [CW-1:0]        out_position,
  output logic [1:0]           out_status,
  output logic [CW-1:0]        out_count
);

  sti_pkg::state_t     state_r, state_nxt;
  sti_pkg::cmd_t       cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [IW-1:0]       index_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic                key_signed_r;

  logic                out_valid_r;
  logic                out_hit_r, hit_nxt;
  logic [CW-1:0]       out_position_r, position_nxt;
  sti_pkg::status_t    out_status_r, status_nxt;

  sti_pkg::cell_ctrl_t ctrl;
  logic                finish, accept, do_ins, do_del;

  logic [DEPTH-1:0]    slot_valid, del_sel, not_below, equal, ge_mask;
  logic [KEY_WIDTH-1:0] entries [DEPTH];
  logic [CW-1:0]       loc_position;
  logic                loc_hit;

  // ---------------- sequencer ----------------
  assign finish   = (state_r == sti_pkg::S_RES) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == sti_pkg::S_IDLE) || finish;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sti_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sti_pkg::S_CMP;
      end
      sti_pkg::S_CMP: begin
        state_nxt = sti_pkg::S_RES;
      end
      sti_pkg::S_RES: begin
        if (finish) state_nxt = in_valid ? sti_pkg::S_CMP : sti_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sti_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.load_flags = 1'b0;
    ctrl.do_ins     = 1'b0;
    ctrl.do_del     = 1'b0;
    case (state_r)
      sti_pkg::S_CMP: begin
        ctrl.load_flags = 1'b1;
      end
      sti_pkg::S_RES: begin
        ctrl.do_ins = finish && do_ins;
        ctrl.do_del = finish && do_del;
      end
      default: begin
        ctrl.load_flags = 1'b0;
      end
    endcase
  end

  // ---------------- result ----------------
  always_comb begin
    hit_nxt      = loc_hit;
    position_nxt = loc_position;
    status_nxt   = sti_pkg::ST_OK;
    do_ins       = 1'b0;
    do_del       = 1'b0;
    count_nxt    = count_r;
    case (cmd_r)
      sti_pkg::CMD_LOOKUP: begin
        status_nxt = loc_hit ? sti_pkg::ST_OK : sti_pkg::ST_NOT_FOUND;
      end
      sti_pkg::CMD_FIND_GE: begin
        status_nxt = (loc_position < count_r) ? sti_pkg::ST_OK : sti_pkg::ST_NOT_FOUND;
      end
      sti_pkg::CMD_INSERT: begin
        if (!loc_hit) begin
          if (count_r >= CW'(DEPTH)) begin
            status_nxt = sti_pkg::ST_FULL;
          end else begin
            do_ins    = 1'b1;
            count_nxt = count_r + {{(CW-1){1'b0}}, 1'b1};
          end
        end
      end
      sti_pkg::CMD_DELETE: begin
        hit_nxt      = 1'b0;
        position_nxt = CW'(index_r);
        if (CW'(index_r) >= count_r) begin
          status_nxt = sti_pkg::ST_RANGE;
        end else begin
          do_del    = 1'b1;
          count_nxt = count_r - {{(CW-1){1'b0}}, 1'b1};
        end
      end
      default: begin
        status_nxt = sti_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sti_pkg::S_IDLE;
      count_r      <= '0;
      key_signed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) key_signed_r <= cfg_wdata;
      if (finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= sti_pkg::cmd_t'(in_cmd);
      key_r   <= in_key;
      index_r <= in_index;
    end
    if (finish) begin
      out_hit_r      <= hit_nxt;
      out_position_r <= position_nxt;
      out_status_r   <= status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_position = out_position_r;
  assign out_status   = out_status_r;
  assign out_count    = count_r;

  // ---------------- cell row ----------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 ge_prev_i;
    logic [KEY_WIDTH-1:0] prev_i, next_i;

    assign slot_valid[i] = count_r > CW'(i);
    assign del_sel[i]    = IW'(i) >= index_r;

    if (i == 0) begin : g_first
      assign ge_prev_i = 1'b0;
      assign prev_i    = key_r;
    end else begin : g_mid
      assign ge_prev_i = ge_mask[i-1];
      assign prev_i    = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_i = entries[i];
    end else begin : g_body
      assign next_i = entries[i+1];
    end

    sti_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (key_r),
      .key_signed(key_signed_r),
      .slot_valid(slot_valid[i]),
      .del_sel   (del_sel[i]),
      .ge        (ge_mask[i]),
      .ge_prev   (ge_prev_i),
      .prev_entry(prev_i),
      .next_entry(next_i),
      .entry     (entries[i]),
      .not_below (not_below[i]),
      .equal     (equal[i])
    );
  end

  sti_locate #(
    .DEPTH(DEPTH),
    .CW   (CW)
  ) u_locate (
    .not_below(not_below),
    .equal    (equal),
    .position (loc_position),
    .hit      (loc_hit),
    .ge_mask  (ge_mask)
  );

endmodule

>>> hdl/sti_cell.sv
// One table slot: holds an entry, compares it against the search key and
// shifts with its neighbors on insert and delete. Depends on sti_pkg.
`timescale 1ns / 1ps

module sti_cell #(
  parameter int KEY_WIDTH = sti_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  sti_pkg::cell_ctrl_t   ctrl,
  input  logic [KEY_WIDTH-1:0]  key,
  input  logic                  key_signed,
  input  logic                  slot_valid,
  input  logic                  del_sel,
  input  logic                  ge,
  input  logic                  ge_prev,
  input  logic [KEY_WIDTH-1:0]  prev_entry,
  input  logic [KEY_WIDTH-1:0]  next_entry,
  output logic [KEY_WIDTH-1:0]  entry,
  output logic                  not_below,
  output logic                  equal
);

  logic [KEY_WIDTH-1:0] entry_r, entry_nxt;
  logic                 not_below_r, equal_r;
  logic [KEY_WIDTH-1:0] sign_flip;
  logic                 below;

  // Flip the sign bit so a signed compare becomes an unsigned one.
  assign sign_flip = {key_signed, {(KEY_WIDTH-1){1'b0}}};
  assign below     = (entry_r ^ sign_flip) < (key ^ sign_flip);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.do_del && del_sel) begin
      entry_nxt = next_entry;
    end else if (ctrl.do_ins && ge) begin
      entry_nxt = ge_prev ? prev_entry : key;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctrl.load_flags) begin
      // Empty slots count as not below so the search stops at the fill level.
      not_below_r <= !slot_valid || !below;
      equal_r     <= slot_valid && (entry_r == key);
    end
  end

  assign entry     = entry_r;
  assign not_below = not_below_r;
  assign equal     = equal_r;

endmodule

>>> hdl/sti_locate.sv
// Finds the lowest slot whose flag is set, gives its index, the hit flag
// and the mask of slots at or above it. Depends on sti_pkg only for DEPTH_DEFAULT.
`timescale 1ns / 1ps

module sti_locate #(
  parameter int DEPTH = sti_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic [DEPTH-1:0] not_below,
  input  logic [DEPTH-1:0] equal,
  output logic [CW-1:0]    position,
  output logic             hit,
  output logic [DEPTH-1:0] ge_mask
);

  logic [DEPTH-1:0] minus_one, onehot, low;
  logic [CW-1:0]    enc;

  assign minus_one = not_below - {{(DEPTH-1){1'b0}}, 1'b1};
  assign onehot    = not_below & ~minus_one;
  assign low       = ~not_below & minus_one;
  assign ge_mask   = ~low;
  assign hit       = |(onehot & equal);

  always_comb begin
    enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (onehot[i]) begin
        enc = enc | CW'(i);
      end
    end
  end

  // No flag set means every slot is full and below the key.
  assign position = (|not_below) ? enc : CW'(DEPTH);

endmodule
